// ----- sv/lpi_pkg.sv -----
// Shared constants, types and helpers of the line pixel interpolator.
`timescale 1ns / 1ps
package lpi_pkg;

  localparam int TileSize  = 64;
  localparam int CoordW    = 6;
  localparam int DescDepth = 2;
  localparam int DescPtrW  = $clog2(DescDepth);
  localparam int DescCntW  = $clog2(DescDepth + 1);

  localparam logic [CoordW-1:0] MaxCoord = CoordW'(TileSize - 1);

  // One line, classified and ordered so that the major coordinate increases.
  typedef struct packed {
    logic              x_major;
    logic              neg;
    logic [CoordW-1:0] maj0;
    logic [CoordW-1:0] min0;
    logic [CoordW-1:0] dmaj;
    logic [CoordW-1:0] adm;
  } desc_t;

  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] v);
    clamp_coord = (v > MaxCoord) ? MaxCoord : v;
  endfunction

endpackage

// ----- sv/line_pixel_interpolator_top.sv -----
// Top level of the line pixel interpolator: front end, descriptor queue, back end.
`timescale 1ns / 1ps
// Usage:
//   Input channel: present two endpoints on start_x_i/start_y_i/end_x_i/end_y_i
//   and raise push; the word is taken at a clock edge with push high and full
//   low. Coordinates above the tile edge saturate to the last tile pixel.
//   Output channel: while empty is low the oldest pixel sits on pixel_x_o,
//   pixel_y_o and last_pixel_o; raise pop to take it. last_pixel_o marks the
//   final pixel of each line; a zero-length line yields a single marked pixel.
//   An idle block moves a taken word through the queue and the stepper
//   registers into the output register. Throughput: one pixel per cycle while
//   the output is not stalled; a line yields (major span + 1) pixels, from 1
//   up to 64, set by the single stepper in the back end. The front end
//   classifies a word in the cycle it is taken and parks it in a two-deep queue,
//   so up to two further lines are held while the back end walks the current one.
//   Reset clears the queue, the stepper and the output register; no line is
//   kept. When the receiver stalls, hold the output word and the stepper;
//   the queue fills and full rises once two lines are waiting.
module line_pixel_interpolator_top import lpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [CoordW-1:0] start_x_i,
  input  logic [CoordW-1:0] start_y_i,
  input  logic [CoordW-1:0] end_x_i,
  input  logic [CoordW-1:0] end_y_i,
  output logic              empty,
  input  logic              pop,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic              last_pixel_o
);

  desc_t front_desc;
  desc_t queue_desc;
  logic  queue_empty;
  logic  queue_rd;

  // Classify the incoming word: clamp, choose major axis, order endpoints
  lpi_front u_front (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .desc_o    (front_desc)
  );

  // Decouple acceptance from pixel stepping
  lpi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_desc),
    .full_o  (full),
    .rd_i    (queue_rd),
    .rdata_o (queue_desc),
    .empty_o (queue_empty)
  );

  // Walk the line, one pixel per cycle while the output is not stalled, with an incremental remainder
  lpi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (queue_desc),
    .desc_empty_i (queue_empty),
    .desc_rd_o    (queue_rd),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

// ----- sv/lpi_front.sv -----
// Front end: clamp endpoints, pick the major axis and order the endpoints.
`timescale 1ns / 1ps
module lpi_front import lpi_pkg::*; (
  input  logic [CoordW-1:0] start_x_i,
  input  logic [CoordW-1:0] start_y_i,
  input  logic [CoordW-1:0] end_x_i,
  input  logic [CoordW-1:0] end_y_i,
  output desc_t             desc_o
);

  logic [CoordW-1:0] ax, ay, bx, by;
  logic [CoordW-1:0] adx, ady;
  logic              x_major;
  logic [CoordW-1:0] ma0, mi0, ma1, mi1;
  logic [CoordW-1:0] maj0, min0, maj1, min1;

  always_comb begin
    ax = clamp_coord(start_x_i);
    ay = clamp_coord(start_y_i);
    bx = clamp_coord(end_x_i);
    by = clamp_coord(end_y_i);
    adx = (bx >= ax) ? (bx - ax) : (ax - bx);
    ady = (by >= ay) ? (by - ay) : (ay - by);
    // Equal spans take x as major
    x_major = (adx >= ady);
    ma0 = x_major ? ax : ay;
    mi0 = x_major ? ay : ax;
    ma1 = x_major ? bx : by;
    mi1 = x_major ? by : bx;
    // Swap so that the major coordinate increases
    if (ma1 < ma0) begin
      maj0 = ma1; min0 = mi1; maj1 = ma0; min1 = mi0;
    end else begin
      maj0 = ma0; min0 = mi0; maj1 = ma1; min1 = mi1;
    end
    desc_o.x_major = x_major;
    desc_o.neg     = (min1 < min0);
    desc_o.maj0    = maj0;
    desc_o.min0    = min0;
    desc_o.dmaj    = maj1 - maj0;
    desc_o.adm     = (min1 < min0) ? (min0 - min1) : (min1 - min0);
  end

endmodule

// ----- sv/lpi_queue.sv -----
// Short queue of line descriptors between the front and back ends.
`timescale 1ns / 1ps
module lpi_queue import lpi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  desc_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output desc_t rdata_o,
  output logic  empty_o
);

  desc_t               mem_q [DescDepth];
  logic [DescPtrW-1:0] wptr_q, rptr_q;
  logic [DescCntW-1:0] cnt_q;
  logic                do_wr, do_rd;

  assign full_o  = (cnt_q == DescCntW'(DescDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == DescPtrW'(DescDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == DescPtrW'(DescDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/lpi_back.sv -----
// Back end: step along the major axis, one pixel a cycle while the output register is free, into it.
`timescale 1ns / 1ps
module lpi_back import lpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  desc_t             desc_i,
  input  logic              desc_empty_i,
  output logic              desc_rd_o,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic              last_pixel_o,
  output logic              empty_o,
  input  logic              pop_i
);

  logic              busy_q, busy_d;
  logic              xmaj_q, neg_q;
  logic [CoordW-1:0] dmaj_q, adm_q;
  logic [CoordW-1:0] maj_q, min_q, rem_q, left_q;
  logic [CoordW-1:0] maj_d, min_d, rem_d, left_d;
  logic              ovld_q, ovld_d;
  logic [CoordW-1:0] px_q, py_q;
  logic              last_q;
  logic              slot_free, advance, load;
  logic [CoordW:0]   rem_sum;

  assign slot_free = !ovld_q || pop_i;
  assign advance   = busy_q && slot_free;
  assign load      = (!busy_q || (advance && (left_q == '0))) && !desc_empty_i;
  assign desc_rd_o = load;

  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_pixel_o = last_q;
  assign empty_o      = !ovld_q;

  always_comb begin
    rem_sum = {1'b0, rem_q} + {1'b0, adm_q};
    maj_d   = maj_q + 1'b1;
    left_d  = left_q - 1'b1;
    // Remainder stays below dmaj, so one subtract keeps it in range
    if (rem_sum >= {1'b0, dmaj_q}) begin
      rem_d = CoordW'(rem_sum - {1'b0, dmaj_q});
      min_d = neg_q ? (min_q - 1'b1) : (min_q + 1'b1);
    end else begin
      rem_d = CoordW'(rem_sum);
      min_d = min_q;
    end
    busy_d = load || (busy_q && !(advance && (left_q == '0)));
    ovld_d = advance || (ovld_q && !pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      xmaj_q <= desc_i.x_major;
      neg_q  <= desc_i.neg;
      dmaj_q <= desc_i.dmaj;
      adm_q  <= desc_i.adm;
      maj_q  <= desc_i.maj0;
      min_q  <= desc_i.min0;
      rem_q  <= '0;
      left_q <= desc_i.dmaj;
    end else if (advance) begin
      maj_q  <= maj_d;
      min_q  <= min_d;
      rem_q  <= rem_d;
      left_q <= left_d;
    end
    if (advance) begin
      px_q   <= xmaj_q ? maj_q : min_q;
      py_q   <= xmaj_q ? min_q : maj_q;
      last_q <= (left_q == '0);
    end
  end

endmodule
